// File: src/aesbc_pkg.sv
// ----------------------------------------------------------------------------
// aesbc_pkg: shared types, tables and round functions
// Beat structs, register indexes, S-box and the AES byte/column operations.
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int MAX_ROUNDS = 14;
    // round keys 0..MAX_ROUNDS, plus the row index one past the last key
    localparam int KEY_ROWS   = MAX_ROUNDS + 2;
    localparam int ROW_W      = $clog2(KEY_ROWS);

    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_KEY_LEN = 3'd4,
        REG_DECRYPT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_beat;

    typedef logic [7:0] t_box [256];

    localparam t_box FWD_BOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // inverse table, derived at elaboration
    function automatic t_box build_inv();
        t_box inv;
        for (int x = 0; x < 256; x++) begin
            inv[FWD_BOX[x]] = 8'(x);
        end
        return inv;
    endfunction

    localparam t_box INV_BOX = build_inv();

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++) begin
            a[i]  = c[31-8*i -: 8];
            a2[i] = xt(a[i]);
            a4[i] = xt(a2[i]);
            a8[i] = xt(a4[i]);
            m2[i] = a2[i];
            m3[i] = a2[i] ^ a[i];
            m9[i] = a8[i] ^ a[i];
            mb[i] = a8[i] ^ a2[i] ^ a[i];
            md[i] = a8[i] ^ a4[i] ^ a[i];
            me[i] = a8[i] ^ a4[i] ^ a2[i];
        end
        if (!inv) begin
            return {m2[0] ^ m3[1] ^ a[2] ^ a[3],
                    a[0] ^ m2[1] ^ m3[2] ^ a[3],
                    a[0] ^ a[1] ^ m2[2] ^ m3[3],
                    m3[0] ^ a[1] ^ a[2] ^ m2[3]};
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
        end
        return o;
    endfunction

    // SubBytes + ShiftRows, or their inverses; byte i sits at bits 127-8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [1:0]   src;
        logic [7:0]   v;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 2'(c - r) : 2'(c + r);
                v   = s[127 - 8*(r + 4*int'(src)) -: 8];
                o[127 - 8*(r + 4*c) -: 8] = inv ? INV_BOX[v] : FWD_BOX[v];
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: src/aesbc_ram.sv
// ----------------------------------------------------------------------------
// aesbc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aesbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/aes_block_cipher_128_192_256_unit.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_128_192_256_unit: AES-128/192/256 ECB block engine
// Iterative engine: one shared round unit, round keys in a small RAM.
// ----------------------------------------------------------------------------
// Sequence: an accepted input beat passes ST_PRIME, ST_ADD0 and ST_ROUND,
//   preceded by ST_KEYGEN (one schedule word per cycle) on the first block
//   after reset or after any write to a mapped config register.
// One block at a time. The round unit does one round per cycle and the key RAM
//   feeds one round key per cycle, but the final round holds on output stall.
// Reset: synchronous, active low; clears control state, config registers and
//   marks the schedule stale. The key RAM needs no clearing.
module aes_block_cipher_128_192_256_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_wdata,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  aesbc_pkg::t_in_beat  i_in_data,
    // output beats
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output aesbc_pkg::t_out_beat o_out_data
);
    import aesbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_PRIME,
        ST_ADD0,
        ST_ROUND
    } t_state;

    // config registers
    logic [63:0] r_key [4];
    logic [1:0]  r_klen;
    logic        r_dec;
    logic        r_sched_ok;

    // sequencer
    t_state      r_st;
    logic [ROW_W-1:0] r_rnd;      // round counter, one row ahead of the key in use
    logic [127:0] r_blk;          // cipher state
    logic        r_out_valid;
    t_out_beat   r_out;

    // key expansion
    logic [5:0]  r_wi;            // schedule word index
    logic [2:0]  r_j;             // word index mod Nk
    logic [3:0]  r_rc;            // round constant index
    logic [31:0] r_win [8];       // last Nk words, newest at 0
    logic [95:0] r_kacc;          // three words of the key being assembled

    // derived
    logic [3:0]  nr;
    logic [2:0]  nk_m1;
    logic [31:0] w_new;
    logic [31:0] w_tmp;
    logic [127:0] rk_full;
    logic [3:0]  rk_idx;
    logic        rk_we;
    logic [ROW_W-1:0] rk_row;
    logic [127:0] rk_wdata;
    logic [ROW_W-1:0] rd_row;
    logic [127:0] rd_key;
    logic        last_rnd;
    logic        out_free;
    logic        out_load;
    logic [127:0] rnd_ss;
    logic [127:0] rnd_out;
    logic        in_acc;

    always_comb begin
        unique case (r_klen)
            2'd0:    begin nr = 4'd10; nk_m1 = 3'd3; end
            2'd1:    begin nr = 4'd12; nk_m1 = 3'd5; end
            default: begin nr = 4'd14; nk_m1 = 3'd7; end   // 3 acts as 256-bit
        endcase
    end

    // one schedule word per cycle
    always_comb begin
        w_tmp = r_win[0];
        if (r_j == 3'd0) begin
            w_tmp = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {rcon(r_rc), 24'h0};
        end else if (nk_m1 == 3'd7 && r_j == 3'd4) begin
            w_tmp = sub_word(r_win[0]);
        end
        if (r_wi < {3'd0, nk_m1} + 6'd1) begin
            w_new = r_wi[0] ? r_key[r_wi[2:1]][31:0] : r_key[r_wi[2:1]][63:32];
        end else begin
            w_new = r_win[nk_m1] ^ w_tmp;
        end
    end

    assign rk_full  = {r_kacc, w_new};
    assign rk_idx   = r_wi[5:2];
    assign rk_we    = (r_st == ST_KEYGEN) && (r_wi[1:0] == 2'd3);
    assign rk_row   = r_dec ? ROW_W'(nr - rk_idx) : ROW_W'(rk_idx);
    assign rk_wdata = (r_dec && rk_idx != 4'd0 && rk_idx != nr) ? mix(rk_full, 1'b1) : rk_full;

    // in the final round keep reading the last key row while the output waits
    assign rd_row   = (r_st == ST_ROUND && last_rnd) ? r_rnd - ROW_W'(1) : r_rnd;

    aesbc_ram #(
        .WIDTH (128),
        .DEPTH (KEY_ROWS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (rk_row),
        .i_wdata (rk_wdata),
        .i_raddr (rd_row),
        .o_rdata (rd_key)
    );

    // shared round unit; key index in ST_ROUND is r_rnd - 1
    assign last_rnd = (r_rnd == nr + 4'd1);
    assign rnd_ss   = sub_shift(r_blk, r_dec);
    assign rnd_out  = (last_rnd ? rnd_ss : mix(rnd_ss, r_dec)) ^ rd_key;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_st == ST_ROUND) && last_rnd && out_free;
    assign in_acc   = i_in_valid && (r_st == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_klen      <= '0;
            r_dec       <= 1'b0;
            r_sched_ok  <= 1'b0;
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rnd       <= '0;
            r_wi        <= '0;
            r_j         <= '0;
            r_rc        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY0:    begin r_key[0] <= i_cfg_wdata; r_sched_ok <= 1'b0; end
                    REG_KEY1:    begin r_key[1] <= i_cfg_wdata; r_sched_ok <= 1'b0; end
                    REG_KEY2:    begin r_key[2] <= i_cfg_wdata; r_sched_ok <= 1'b0; end
                    REG_KEY3:    begin r_key[3] <= i_cfg_wdata; r_sched_ok <= 1'b0; end
                    REG_KEY_LEN: begin r_klen <= i_cfg_wdata[1:0]; r_sched_ok <= 1'b0; end
                    REG_DECRYPT: begin r_dec <= i_cfg_wdata[0]; r_sched_ok <= 1'b0; end
                    default:     ;   // unmapped index, ignored
                endcase
            end

            // drained beat; a new result loaded this cycle takes its place
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_blk <= {i_in_data.block_high, i_in_data.block_low};
                        r_rnd <= '0;
                        if (r_sched_ok) begin
                            r_st <= ST_PRIME;
                        end else begin
                            r_st <= ST_KEYGEN;
                            r_wi <= '0;
                            r_j  <= '0;
                            r_rc <= '0;
                        end
                    end
                end
                ST_KEYGEN: begin
                    for (int k = 1; k < 8; k++) begin
                        r_win[k] <= r_win[k-1];
                    end
                    r_win[0] <= w_new;
                    r_kacc   <= {r_kacc[63:0], w_new};
                    r_wi     <= r_wi + 6'd1;
                    r_j      <= (r_j == nk_m1) ? 3'd0 : r_j + 3'd1;
                    if (r_j == 3'd0 && r_wi > {3'd0, nk_m1}) begin
                        r_rc <= r_rc + 4'd1;
                    end
                    if (r_wi == {nr, 2'd3}) begin
                        r_sched_ok <= 1'b1;
                        r_st       <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    r_rnd <= r_rnd + ROW_W'(1);
                    r_st  <= ST_ADD0;
                end
                ST_ADD0: begin
                    r_blk <= r_blk ^ rd_key;
                    r_rnd <= r_rnd + ROW_W'(1);
                    r_st  <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (!last_rnd) begin
                        r_blk <= rnd_out;
                        r_rnd <= r_rnd + ROW_W'(1);
                    end else if (out_free) begin
                        // result loads once the output frees; until then the state holds with the same key row
                        r_out       <= rnd_out;
                        r_out_valid <= 1'b1;
                        r_st        <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_st != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted beat always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_st == ST_KEYGEN || r_st == ST_PRIME))
        else $error("accepted beat did not start work");

    // expansion only runs on a stale schedule
    a_keygen_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_KEYGEN) |-> !r_sched_ok)
        else $error("key expansion with valid schedule");

    // a new result only comes from the final round
    a_out_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_st) == ST_ROUND && r_st == ST_IDLE))
        else $error("result not from final round");

    // rounds never run past the last key row
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_ROUND) |-> (r_rnd >= 4'd2 && r_rnd <= nr + 4'd1))
        else $error("round index out of range");
endmodule

// File: test/aesbc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aesbc_checker: AES block predictor and result scoreboard
// Mirrors the config writes, builds its own key schedule, predicts every
// accepted input beat and compares accepted output beats in order.
// ----------------------------------------------------------------------------
module aesbc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  aesbc_pkg::t_in_beat  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  aesbc_pkg::t_out_beat i_out_data,
    output int                   o_errors,
    output int                   o_pending
);
    import aesbc_pkg::*;

    logic [63:0]  key_w [4];
    logic [1:0]   key_len;
    logic         dec_mode;
    logic [127:0] rkeys [15];
    logic         sched_ok;
    t_out_beat    blocks_due [$];
    logic [7:0]   sbox [256];
    logic [7:0]   ibox [256];

    function automatic logic [7:0] gf2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf2(a);
        end
        return p;
    endfunction

    function automatic logic [127:0] mixcols(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
            if (!inv)
                o[127-32*c -: 32] = {gfmul(a0,2)^gfmul(a1,3)^a2^a3, a0^gfmul(a1,2)^gfmul(a2,3)^a3,
                                     a0^a1^gfmul(a2,2)^gfmul(a3,3), gfmul(a0,3)^a1^a2^gfmul(a3,2)};
            else
                o[127-32*c -: 32] = {
                    gfmul(a0,14)^gfmul(a1,11)^gfmul(a2,13)^gfmul(a3,9),
                    gfmul(a0,9)^gfmul(a1,14)^gfmul(a2,11)^gfmul(a3,13),
                    gfmul(a0,13)^gfmul(a1,9)^gfmul(a2,14)^gfmul(a3,11),
                    gfmul(a0,11)^gfmul(a1,13)^gfmul(a2,9)^gfmul(a3,14)};
        end
        return o;
    endfunction

    function automatic logic [127:0] subshift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int src;
        logic [7:0] v;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                v = s[127 - 8*(r + 4*src) -: 8];
                o[127 - 8*(r + 4*c) -: 8] = inv ? ibox[v] : sbox[v];
            end
        return o;
    endfunction

    function automatic logic [31:0] subw(input logic [31:0] t);
        return {sbox[t[31:24]], sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]};
    endfunction

    function automatic int num_rounds();
        return key_len == 0 ? 10 : key_len == 1 ? 12 : 14;
    endfunction

    task automatic expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0] rc;
        int nk, nr, src;
        nk = key_len == 0 ? 4 : key_len == 1 ? 6 : 8;
        nr = num_rounds();
        for (int i = 0; i < nk; i++)
            w[i] = i[0] ? key_w[i>>1][31:0] : key_w[i>>1][63:32];
        for (int i = nk; i < 60; i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                rc = 8'h01;
                for (int j = 0; j < (i / nk - 1) % 10; j++) rc = gf2(rc);
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int r = 0; r <= nr; r++) begin
            src = dec_mode ? nr - r : r;
            rkeys[r] = {w[4*src], w[4*src+1], w[4*src+2], w[4*src+3]};
            if (dec_mode && r > 0 && r < nr) rkeys[r] = mixcols(rkeys[r], 1'b1);
        end
        sched_ok = 1;
    endtask

    function automatic t_out_beat cipher_block(input t_in_beat b);
        logic [127:0] s;
        int nr;
        nr = num_rounds();
        s = {b.block_high, b.block_low} ^ rkeys[0];
        for (int r = 1; r <= nr; r++) begin
            s = subshift(s, dec_mode);
            if (r < nr) s = mixcols(s, dec_mode);
            s ^= rkeys[r];
        end
        return t_out_beat'(s);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    // S-box by inversion in GF(2^8) plus the affine map
    initial begin
        logic [7:0] inv, acc, b;
        for (int x = 0; x < 256; x++) begin
            inv = 0;
            if (x != 0) begin
                acc = 1;
                for (int i = 0; i < 254; i++) acc = gfmul(acc, 8'(x));
                inv = acc;
            end
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox[x] = b;
            ibox[b] = 8'(x);
        end
        o_errors = 0;
    end

    assign o_pending = blocks_due.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_w[i] = 0;
            key_len  = 0;
            dec_mode = 0;
            sched_ok = 0;
            blocks_due.delete();
        end else begin
            if (i_cfg_we) begin
                // unmapped indexes leave the schedule alone
                case (i_cfg_idx)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                        key_w[i_cfg_idx[1:0]] = i_cfg_wdata;
                        sched_ok = 0;
                    end
                    REG_KEY_LEN: begin
                        key_len  = i_cfg_wdata[1:0];
                        sched_ok = 0;
                    end
                    REG_DECRYPT: begin
                        dec_mode = i_cfg_wdata[0];
                        sched_ok = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (!sched_ok) expand_schedule();
                blocks_due.push_back(cipher_block(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (blocks_due.size() == 0) begin
                    report_mismatch("unexpected beat", i_out_data.result_high, 64'h0);
                end else begin
                    want = blocks_due.pop_front();
                    if (i_out_data.result_high !== want.result_high)
                        report_mismatch("result_high", i_out_data.result_high, want.result_high);
                    if (i_out_data.result_low !== want.result_low)
                        report_mismatch("result_low", i_out_data.result_low, want.result_low);
                end
            end
        end
    end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: AES block engine testbench
// Walks key lengths and directions, sends directed and random blocks with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import aesbc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 100;  // idle margin after the last result is in

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [63:0] cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_stall;
    t_in_beat    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_out_beat   out_data;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          steady = 0;   // no-idle stretch when set

    always #5 i_clk = ~i_clk;

    aes_block_cipher_128_192_256_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    aesbc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls at random with probability 17/100, none during the steady stretch
    always @(posedge i_clk)
        out_stall <= !steady && ($urandom_range(99) < 17);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we    <= 1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 0;
    endtask

    // one beat; idles first at random, then holds until accepted; valid stays
    // up after acceptance so back-to-back beats need no gap
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while (!steady && $urandom_range(99) < 17) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_data  <= '{block_high: hi, block_low: lo};
        do @(posedge i_clk); while (in_stall);
    endtask

    // engine idle: all results in, then a margin of DRAIN_CYCLES
    task automatic wait_idle();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_keys(input logic [1:0] klen, input logic dec,
                             input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KEY_LEN, {$urandom, 30'h0, klen});   // upper bits ignored
        write_reg(REG_DECRYPT, {63'(rand64()), dec});
    endtask

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset defaults: all-zero 128-bit key, encrypt
        send_block(64'h0, 64'h0);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        wait_idle();

        // directed: FIPS-197 style keys, every length, both directions
        for (int kl = 0; kl < 4; kl++) begin
            for (int d = 0; d < 2; d++) begin
                load_keys(2'(kl), d[0], 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                          64'h1011121314151617, 64'h18191a1b1c1d1e1f);
                send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
                send_block(64'h0, 64'hffff_ffff_ffff_ffff);
                wait_idle();
            end
        end
        // all-ones key, then a single rewrite of one register mid-run
        load_keys(2'd2, 1'b0, '1, '1, '1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        wait_idle();
        write_reg(REG_KEY3, 64'h0);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        wait_idle();

        // random phases with random keys and settings
        n = 0;
        while (n < 1400) begin
            load_keys(2'($urandom_range(3)), 1'($urandom), rand64(), rand64(),
                      rand64(), rand64());
            steady = (n == 400) || ($urandom_range(5) == 0);
            for (int i = 0; i < 40; i++) begin
                send_block(rand64(), rand64());
                if (i == 20) wait_idle();   // sender holds off until all results are in
                n++;
            end
            wait_idle();
            steady = 0;
        end

        wait_idle();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
